// ===== sv/rbtm_pkg.sv =====
// Shared types and codes for the rel32 branch target matcher.
// No dependencies; imported by rbtm_cell and the top level.
package rbtm_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CODE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [7:0] OP_CALL = 8'hE8;
    localparam logic [7:0] OP_JUMP = 8'hE9;
    localparam logic [2:0] BRANCH_LEN = 3'd5;

    typedef struct packed {
        logic        tok_valid;
        logic [1:0]  op;
        logic [31:0] key_off;
        logic [63:0] key_id;
        logic        hit;
        logic        inserted;
        logic [63:0] acc_id;
        logic [31:0] acc_off;
    } token_t;

endpackage

// ===== sv/rbtm_cell.sv =====
// One table cell: holds one mapping and updates the token passing through it.
// Depends on rbtm_pkg.
module rbtm_cell
    import rbtm_pkg::*;
#(
    parameter int CNT_W      = 9,
    parameter int CELL_INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] entry_count,
    input  token_t           token_in,
    output token_t           token_out
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    token_t      token_reg;
    token_t      token_next;
    logic [31:0] off_reg;
    logic [31:0] off_next;
    logic [63:0] id_reg;
    logic [63:0] id_next;
    logic        used;

    assign used = MY_INDEX < entry_count;

    always_comb
    begin
        token_next = token_in;
        off_next   = off_reg;
        id_next    = id_reg;
        if (token_in.tok_valid)
        begin
            case (token_in.op)
                ACT_LOAD:
                begin
                    if (used && off_reg == token_in.key_off)
                    begin
                        token_next.hit = 1'b1;
                        if (token_in.key_id < id_reg)
                        begin
                            id_next = token_in.key_id;
                        end
                    end
                    else if (!used && MY_INDEX == entry_count && !token_in.hit
                             && !token_in.inserted)
                    begin
                        off_next            = token_in.key_off;
                        id_next             = token_in.key_id;
                        token_next.inserted = 1'b1;
                    end
                end
                ACT_CODE:
                begin
                    if (used && off_reg == token_in.key_off && !token_in.hit)
                    begin
                        token_next.hit    = 1'b1;
                        token_next.acc_id = id_reg;
                    end
                end
                ACT_QUERY:
                begin
                    if (used && id_reg == token_in.key_id
                        && (!token_in.hit || off_reg < token_in.acc_off))
                    begin
                        token_next.hit     = 1'b1;
                        token_next.acc_off = off_reg;
                        token_next.acc_id  = id_reg;
                    end
                end
                default:
                begin
                    token_next.tok_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        id_reg  <= id_next;
    end

    assign token_out = token_reg;

endmodule

// ===== sv/rel32_branch_target_matcher_core.sv =====
// Top level of the rel32 branch target matcher: byte window, launch and result.
// Depends on rbtm_pkg and rbtm_cell.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  command  | start / busy           | action code_start code_byte entry_offset
//           |                        | entry_id query_id
//  result   | result_valid (1 cycle) | result_type found branch_position mapped_id
//           |                        | mapped_offset branch_kind table_overflow
//  config   | cfg_valid / cfg_ready  | cfg_data (source_offset)
//
// A load with nonzero offset and id, a query, or a code byte whose window holds a branch
// with a valid target walks the chain of TABLE_DEPTH cells one cell per cycle while busy
// stays high; busy falls in the same cycle that any result is shown.
// Other code bytes and ignored items do not raise busy. Reset empties the table,
// window, position and overflow flag at once. The result strobe cannot be stalled.
module rel32_branch_target_matcher_core
    import rbtm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic        code_start,
    input  logic [7:0]  code_byte,
    input  logic [31:0] entry_offset,
    input  logic [63:0] entry_id,
    input  logic [63:0] query_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic        result_type,
    output logic        found,
    output logic [31:0] branch_position,
    output logic [63:0] mapped_id,
    output logic [31:0] mapped_offset,
    output logic        branch_kind,
    output logic        table_overflow
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [31:0]      src_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [39:0]      window_reg, window_next;
    logic [2:0]       fill_reg, fill_next;
    logic [31:0]      pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic             busy_reg, busy_next;
    logic [31:0]      bpos_reg, bpos_next;
    logic             kind_reg, kind_next;
    token_t           launch_reg, launch_next;
    logic             rv_reg, rv_next;
    logic             rtype_reg, rtype_next;
    logic             rfound_reg, rfound_next;
    logic [31:0]      rpos_reg, rpos_next;
    logic [63:0]      rid_reg, rid_next;
    logic [31:0]      roff_reg, roff_next;
    logic             rkind_reg, rkind_next;

    token_t chain [0:TABLE_DEPTH];

    logic        accept;
    logic [39:0] win0;
    logic [2:0]  fill0;
    logic [31:0] pos0;
    logic [39:0] win_new;
    logic [2:0]  fill_new;
    logic [7:0]  opcode;
    logic [31:0] rel;
    logic [31:0] opos;
    logic [34:0] target;
    logic        candidate;
    token_t      tail;

    assign accept = start && !busy_reg;
    assign tail   = chain[TABLE_DEPTH];

    always_comb
    begin
        win0     = code_start ? 40'd0 : window_reg;
        fill0    = code_start ? 3'd0 : fill_reg;
        pos0     = code_start ? 32'd0 : pos_reg;
        win_new  = {win0[31:0], code_byte};
        fill_new = (fill0 < BRANCH_LEN) ? fill0 + 3'd1 : fill0;
        opcode   = win_new[39:32];
        rel      = {win_new[7:0], win_new[15:8], win_new[23:16], win_new[31:24]};
        opos     = pos0 - 32'd4;
        target   = {3'b000, src_reg} + {3'b000, opos} + 35'd5 + {{3{rel[31]}}, rel};
        candidate = (fill_new == BRANCH_LEN) && (opcode == OP_CALL || opcode == OP_JUMP)
                    && !target[34] && (target[33:0] != 34'd0) && (target[33:32] == 2'b00);
    end

    always_comb
    begin
        count_next  = count_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        busy_next   = busy_reg;
        bpos_next   = bpos_reg;
        kind_next   = kind_reg;
        launch_next = '0;
        rv_next     = 1'b0;
        rtype_next  = rtype_reg;
        rfound_next = rfound_reg;
        rpos_next   = rpos_reg;
        rid_next    = rid_reg;
        roff_next   = roff_reg;
        rkind_next  = rkind_reg;

        if (accept)
        begin
            case (action)
                ACT_LOAD:
                begin
                    if (entry_offset != 32'd0 && entry_id != 64'd0)
                    begin
                        launch_next.tok_valid = 1'b1;
                        launch_next.op        = ACT_LOAD;
                        launch_next.key_off   = entry_offset;
                        launch_next.key_id    = entry_id;
                        busy_next             = 1'b1;
                    end
                end
                ACT_CODE:
                begin
                    window_next = win_new;
                    fill_next   = fill_new;
                    pos_next    = (pos0 != 32'hFFFF_FFFF) ? pos0 + 32'd1 : pos0;
                    if (candidate)
                    begin
                        launch_next.tok_valid = 1'b1;
                        launch_next.op        = ACT_CODE;
                        launch_next.key_off   = target[31:0];
                        bpos_next             = opos;
                        kind_next             = (opcode == OP_JUMP);
                        busy_next             = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    launch_next.tok_valid = 1'b1;
                    launch_next.op        = ACT_QUERY;
                    launch_next.key_id    = query_id;
                    busy_next             = 1'b1;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end

        if (tail.tok_valid)
        begin
            busy_next = 1'b0;
            case (tail.op)
                ACT_LOAD:
                begin
                    if (tail.inserted)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (!tail.hit)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_CODE:
                begin
                    rv_next     = tail.hit;
                    rtype_next  = 1'b0;
                    rfound_next = 1'b1;
                    rpos_next   = bpos_reg;
                    rid_next    = tail.acc_id;
                    roff_next   = tail.key_off;
                    rkind_next  = kind_reg;
                end
                ACT_QUERY:
                begin
                    rv_next     = 1'b1;
                    rtype_next  = 1'b1;
                    rfound_next = tail.hit;
                    rpos_next   = 32'd0;
                    rid_next    = tail.hit ? tail.acc_id : 64'd0;
                    roff_next   = tail.hit ? tail.acc_off : 32'd0;
                    rkind_next  = 1'b0;
                end
                default:
                begin
                    rv_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg    <= 32'd0;
            count_reg  <= '0;
            window_reg <= 40'd0;
            fill_reg   <= 3'd0;
            pos_reg    <= 32'd0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            launch_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                src_reg <= cfg_data;
            end
            count_reg  <= count_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            ovf_reg    <= ovf_next;
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bpos_reg   <= bpos_next;
        kind_reg   <= kind_next;
        rtype_reg  <= rtype_next;
        rfound_reg <= rfound_next;
        rpos_reg   <= rpos_next;
        rid_reg    <= rid_next;
        roff_reg   <= roff_next;
        rkind_reg  <= rkind_next;
    end

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rbtm_cell #(
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .entry_count (count_reg),
            .token_in    (chain[i]),
            .token_out   (chain[i+1])
        );
    end

    assign busy            = busy_reg;
    assign cfg_ready       = 1'b1;
    assign result_valid    = rv_reg;
    assign result_type     = rtype_reg;
    assign found           = rfound_reg;
    assign branch_position = rpos_reg;
    assign mapped_id       = rid_reg;
    assign mapped_offset   = roff_reg;
    assign branch_kind     = rkind_reg;
    assign table_overflow  = ovf_reg;

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("Result shown while a lookup is still running.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_QUERY) |=> busy)
        else $error("A query item did not start a lookup.");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(table_overflow) |-> table_overflow)
        else $error("Overflow flag cleared without reset.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds table depth.");

endmodule
